>>> rtl/swm_pkg.sv
// Shared types and constants for the sliding window mean unit.
package swm_pkg;

	localparam int CFG_W     = 7;
	localparam int ADDR_W    = 3;
	localparam int APB_W     = 32;
	localparam int PORT_W    = 32;
	localparam int MEAN_W    = 32;

	localparam logic [ADDR_W-3:0]  REG_WINDOW_SIZE   = 1'b0;
	localparam logic [CFG_W-1:0]   WINDOW_SIZE_RESET = 7'd1;

	typedef struct packed {
		logic [CFG_W-1:0] window_size;
		logic             restart;
	} swm_cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} swm_div_status_t;

endpackage

>>> rtl/swm_if.sv
// Valid/ready channel interfaces for samples and results.
interface swm_in_if import swm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PORT_W-1:0] sample;
	logic              first_of_series;
	logic              last_of_series;

	modport source (output valid, output sample, output first_of_series,
		output last_of_series, input ready);
	modport sink (input valid, input sample, input first_of_series,
		input last_of_series, output ready);
endinterface

interface swm_out_if import swm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MEAN_W-1:0] window_mean;
	logic              series_too_short;

	modport source (output valid, output window_mean, output series_too_short,
		input ready);
	modport sink (input valid, input window_mean, input series_too_short,
		output ready);
endinterface

>>> rtl/swm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/swm_regs.sv
// APB configuration register block holding the window size.
module swm_regs import swm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready,
	output swm_cfg_t          cfg
);

	logic [CFG_W-1:0] window_size_q;
	logic             sel_window;
	logic             wr;

	assign pready     = 1'b1;
	assign sel_window = (paddr[ADDR_W-1:2] == REG_WINDOW_SIZE);
	assign wr         = psel && penable && pwrite && pready && sel_window;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WINDOW_SIZE_RESET;
		end else if (wr) begin
			window_size_q <= pwdata[CFG_W-1:0];
		end
	end

	assign prdata = sel_window ? APB_W'(window_size_q) : '0;

	assign cfg.window_size = window_size_q;
	assign cfg.restart     = wr;

endmodule

>>> rtl/swm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module swm_div import swm_pkg::*; #(
	parameter int DVD_W = 38,
	parameter int DSR_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DSR_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output swm_div_status_t  status
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DSR_W:0]   trial;
	logic [DSR_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = (trial >= {1'b0, dsr_q});
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift in one dividend bit, shift out one quotient bit
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
		end
	end

	assign quotient    = dvd_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

>>> rtl/sliding_window_mean_unit.sv
// Top level of the sliding window mean unit.
//
// Samples arrive on the valid/ready channel "samples"; a transfer happens when
// valid and ready are both high. Each sample enters a ring of the latest
// window_size samples and updates a running sum. Once the series holds a full
// window, the sample yields the truncated mean on the "results" channel. A
// series that ends (last_of_series) before its window fills yields one result
// with series_too_short set and a zero mean. first_of_series drops any
// unfinished series. Writing window_size over APB restarts the series.
// A sample that yields a mean passes through the states S_READ, S_UPDATE, S_DIV
// and S_EMIT; in S_DIV the bit-serial divider resolves one quotient bit per
// cycle over the running sum. A sample that ends a short series skips S_DIV,
// and other samples return from S_UPDATE to S_IDLE. The ring is read through
// one RAM port with registered read data. One sample is processed at a time.
// Reset clears the series state and sets window_size to 1. A stalled result
// waits in the output register; the next sample is still taken, and only a
// second result waits until the first has been transferred.
module sliding_window_mean_unit import swm_pkg::*; #(
	parameter int WINDOW_MAX  = 64,
	parameter int SAMPLE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_W-1:0]  pwdata,
	output logic [APB_W-1:0]  prdata,
	output logic              pready,
	swm_in_if.sink            samples,
	swm_out_if.source         results
);

	localparam int SW    = (SAMPLE_BITS < PORT_W) ? SAMPLE_BITS : PORT_W;
	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int SUM_W = SW + PTR_W;
	localparam int WCAP  = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
	localparam int CW    = ((PTR_W > CFG_W) ? PTR_W : CFG_W) + 1;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_READ   = 5'b00010,
		S_UPDATE = 5'b00100,
		S_DIV    = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t              state_q;
	swm_cfg_t            cfg;
	swm_div_status_t     div_st;
	logic [SUM_W-1:0]    quot;
	logic [CFG_W-1:0]    w_eff;
	logic [CFG_W-1:0]    fill_q;
	logic [CFG_W-1:0]    fill_inc;
	logic [PTR_W-1:0]    ptr_q;
	logic [PTR_W-1:0]    ptr_next;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_new;
	logic [SUM_W-1:0]    old_val;
	logic [SW-1:0]       sample_q;
	logic                last_q;
	logic [SW-1:0]       ram_rdata;
	logic                full;
	logic                full_after;
	logic                ptr_wrap;
	logic                accept;
	logic                div_start;
	logic [MEAN_W-1:0]   res_mean_q;
	logic                res_err_q;
	logic                out_valid_q;
	logic [MEAN_W-1:0]   out_mean_q;
	logic                out_err_q;
	logic                out_free;

	swm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	swm_ram #(
		.WIDTH (SW),
		.DEPTH (WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (state_q == S_UPDATE),
		.waddr (ptr_q),
		.wdata (sample_q),
		.re    (state_q == S_READ),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	swm_div #(
		.DVD_W (SUM_W),
		.DSR_W (CFG_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_new),
		.divisor  (w_eff),
		.quotient (quot),
		.status   (div_st)
	);

	always_comb begin
		if (cfg.window_size == '0) begin
			w_eff = CFG_W'(1);
		end else if (cfg.window_size > CFG_W'(WCAP)) begin
			w_eff = CFG_W'(WCAP);
		end else begin
			w_eff = cfg.window_size;
		end
	end

	assign accept     = samples.valid && samples.ready;
	assign samples.ready = (state_q == S_IDLE);
	assign full       = (fill_q >= w_eff);
	assign fill_inc   = fill_q + 1'b1;
	assign full_after = full || (fill_inc >= w_eff);
	assign ptr_wrap   = ((CW'(ptr_q) + CW'(1)) >= CW'(w_eff));
	assign ptr_next   = ptr_wrap ? '0 : ptr_q + 1'b1;
	assign old_val    = full ? SUM_W'(ram_rdata) : '0;
	assign sum_new    = sum_q - old_val + SUM_W'(sample_q);
	assign div_start  = (state_q == S_UPDATE) && full_after;
	assign out_free   = !out_valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sum_q   <= '0;
			fill_q  <= '0;
			ptr_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
						if (samples.first_of_series) begin
							sum_q  <= '0;
							fill_q <= '0;
							ptr_q  <= '0;
						end
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					sum_q  <= last_q ? '0 : sum_new;
					fill_q <= last_q ? '0 : (full ? fill_q : fill_inc);
					ptr_q  <= last_q ? '0 : ptr_next;
					if (full_after) begin
						state_q <= S_DIV;
					end else if (last_q) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cfg.restart) begin
				sum_q  <= '0;
				fill_q <= '0;
				ptr_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= samples.sample[SW-1:0];
			last_q   <= samples.last_of_series;
		end
		if (state_q == S_UPDATE) begin
			res_mean_q <= '0;
			res_err_q  <= 1'b1;
		end else if (state_q == S_DIV && div_st.done) begin
			res_mean_q <= MEAN_W'(quot);
			res_err_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_mean_q <= res_mean_q;
			out_err_q  <= res_err_q;
		end
	end

	assign results.valid            = out_valid_q;
	assign results.window_mean      = out_mean_q;
	assign results.series_too_short = out_err_q;

endmodule
